// File: rtl/core/suffix_array_lcp_builder_core_assert.svh
// Assertion macros shared by the suffix array builder core.
// Depends on nothing; files that assert take it in by include.
`ifndef SUFFIX_ARRAY_LCP_BUILDER_CORE_ASSERT_SVH
`define SUFFIX_ARRAY_LCP_BUILDER_CORE_ASSERT_SVH

// The consequent must hold in the clock after the antecedent.
`define SALB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("suffix array core assertion failed");

// The consequent must hold in the same clock as the antecedent.
`define SALB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("suffix array core assertion failed");

`endif

// File: rtl/core/salb_pkg.sv
// Shared constants, codes and controller/datapath types of the suffix array core.
// Depends on nothing.
`default_nettype none

package salb_pkg;

  localparam int MaxLen = 1024;
  localparam int AddrW  = $clog2(MaxLen);
  localparam int LenW   = AddrW + 1;
  localparam int SymW   = 5;
  localparam int CmdW   = 2;
  localparam int StatW  = 2;

  localparam logic [CmdW-1:0] CmdAppend = 2'd0;
  localparam logic [CmdW-1:0] CmdBuild  = 2'd1;
  localparam logic [CmdW-1:0] CmdRead   = 2'd2;

  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StTrunc = 2'd1;
  localparam logic [StatW-1:0] StBad   = 2'd2;

  typedef enum logic [5:0] {
    OpIdle, OpInitRd, OpInitWr, OpClr,
    OpCnt1, OpCnt2, OpCnt3, OpCnt4,
    OpPre1, OpPre2,
    OpPlc1, OpPlc2, OpPlc3, OpPlc4,
    OpSkInit, OpSkA, OpSkB1, OpSkB2,
    OpCls1, OpCls2, OpCls3, OpCls4,
    OpCp1, OpCp2, OpRound,
    OpIsa1, OpIsa2,
    OpLcp1, OpLcp2, OpLcp3, OpLcp4, OpLcp5, OpLcp6, OpLcpEnd,
    OpDone
  } op_e;

  typedef struct packed {
    op_e  op;
    logic busy;
  } ctl_t;

  typedef struct packed {
    logic last;    // loop index is at its final element
    logic zero;    // suffix has rank zero
    logic more;    // both LCP probes lie inside the string
    logic eq;      // LCP probe symbols match
    logic empty;   // no symbols stored
    logic sorted;  // every suffix has its own class
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/salb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module salb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/salb_datapath.sv
// Datapath of the suffix array core: string, sort and LCP memories, loop registers.
// Depends on salb_pkg and salb_ram; driven by commands from salb_ctrl.
`default_nettype none

module salb_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  salb_pkg::ctl_t                   ctl_i,
  output salb_pkg::sts_t                   sts_o,
  input  logic                             start_i,
  input  logic [salb_pkg::CmdW-1:0]        cmd_i,
  input  logic [salb_pkg::SymW-1:0]        symbol_i,
  input  logic [salb_pkg::LenW-1:0]        rank_i,
  output logic                             result_valid_o,
  output logic [salb_pkg::AddrW-1:0]       position_o,
  output logic [salb_pkg::AddrW-1:0]       lcp_o,
  output logic [salb_pkg::LenW-1:0]        text_len_o,
  output logic [salb_pkg::StatW-1:0]       status_o
);

  localparam int AW = salb_pkg::AddrW;
  localparam int LW = salb_pkg::LenW;
  localparam int SW = salb_pkg::SymW;

  logic          txt_we, sa_we, tmp_we, rk_we, rkn_we, bkt_we, isa_we, lcp_we;
  logic [AW-1:0] txt_wa, sa_wa, tmp_wa, rk_wa, rkn_wa, bkt_wa, isa_wa, lcp_wa;
  logic [AW-1:0] txt_ra, sa_ra, tmp_ra, rk_ra, rkn_ra, bkt_ra, isa_ra, lcp_ra;
  logic [SW-1:0] txt_wd, txt_rd;
  logic [AW-1:0] sa_wd, tmp_wd, rk_wd, rkn_wd, isa_wd, lcp_wd;
  logic [AW-1:0] sa_rd, tmp_rd, rk_rd, rkn_rd, isa_rd, lcp_rd;
  logic [LW-1:0] bkt_wd, bkt_rd;

  logic [LW-1:0] len_q, len_d, i_q, i_d, w_q, w_d, k_q, k_d, h_q, h_d, sum_q, sum_d;
  logic          ovf_q, ovf_d, built_q, built_d, qv_q, qv_d, qbad_q, qbad_d;
  logic [AW-1:0] p_q, p_d, v_q, v_d, b_q, b_d, cls_q, cls_d;
  logic [AW-1:0] k1_q, k1_d, pk1_q, pk1_d, pk2_q, pk2_d, r_q, r_d, j_q, j_d;
  logic          inr_q, inr_d, pinr_q, pinr_d;
  logic [SW-1:0] c_q, c_d;

  logic          go;
  logic [LW-1:0] lim_m1, eff_len, rank_m1, len_m1;
  logic [LW:0]   ih_sum, jh_sum, bk_sum;
  logic          differ;

  assign go      = start_i && !ctl_i.busy;
  assign len_m1  = len_q - LW'(1);
  assign rank_m1 = rank_i - LW'(1);
  assign eff_len = built_q ? '0 : len_q;
  assign ih_sum  = (LW+1)'(i_q) + (LW+1)'(h_q);
  assign jh_sum  = (LW+1)'(j_q) + (LW+1)'(h_q);
  assign bk_sum  = (LW+1)'(b_q) + (LW+1)'(k_q);
  assign lim_m1  = (ctl_i.op == salb_pkg::OpClr || ctl_i.op == salb_pkg::OpPre1 ||
                    ctl_i.op == salb_pkg::OpPre2) ? LW'(salb_pkg::MaxLen - 1) : len_m1;

  // Two neighbors in sorted order fall in different classes when their key pairs differ.
  assign differ = (k1_q != pk1_q) || (inr_q != pinr_q) || (inr_q && rk_rd != pk2_q);

  assign sts_o.last   = (i_q == lim_m1);
  assign sts_o.zero   = (isa_rd == '0);
  assign sts_o.more   = (ih_sum < (LW+1)'(len_q)) && (jh_sum < (LW+1)'(len_q));
  assign sts_o.eq     = (txt_rd == c_q);
  assign sts_o.empty  = (len_q == '0);
  assign sts_o.sorted = (cls_q == len_m1[AW-1:0]) || (k_q >= len_q);

  always_comb begin
    txt_we = 1'b0; txt_wa = '0; txt_wd = '0; txt_ra = '0;
    sa_we  = 1'b0; sa_wa  = '0; sa_wd  = '0; sa_ra  = '0;
    tmp_we = 1'b0; tmp_wa = '0; tmp_wd = '0; tmp_ra = '0;
    rk_we  = 1'b0; rk_wa  = '0; rk_wd  = '0; rk_ra  = '0;
    rkn_we = 1'b0; rkn_wa = '0; rkn_wd = '0; rkn_ra = '0;
    bkt_we = 1'b0; bkt_wa = '0; bkt_wd = '0; bkt_ra = '0;
    isa_we = 1'b0; isa_wa = '0; isa_wd = '0; isa_ra = '0;
    lcp_we = 1'b0; lcp_wa = '0; lcp_wd = '0; lcp_ra = '0;
    len_d = len_q; ovf_d = ovf_q; built_d = built_q; qv_d = 1'b0; qbad_d = qbad_q;
    i_d = i_q; w_d = w_q; k_d = k_q; h_d = h_q; sum_d = sum_q;
    p_d = p_q; v_d = v_q; b_d = b_q; cls_d = cls_q;
    k1_d = k1_q; pk1_d = pk1_q; pk2_d = pk2_q; r_d = r_q; j_d = j_q;
    inr_d = inr_q; pinr_d = pinr_q; c_d = c_q;

    unique case (ctl_i.op) inside
      salb_pkg::OpIdle: begin
        i_d = '0;
        k_d = LW'(1);
        h_d = '0;
        if (go) begin
          case (cmd_i)
            salb_pkg::CmdAppend: begin
              if (built_q) begin
                built_d = 1'b0;
                ovf_d   = 1'b0;
                len_d   = '0;
              end
              if (eff_len < LW'(salb_pkg::MaxLen)) begin
                txt_we = 1'b1;
                txt_wa = eff_len[AW-1:0];
                txt_wd = symbol_i;
                len_d  = eff_len + LW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            salb_pkg::CmdRead: begin
              sa_ra  = rank_m1[AW-1:0];
              lcp_ra = rank_m1[AW-1:0];
              qv_d   = 1'b1;
              qbad_d = !built_q || (rank_i == '0) || (rank_i > len_q);
            end
            default: begin
            end
          endcase
        end
      end
      salb_pkg::OpInitRd: begin
        txt_ra = i_q[AW-1:0];
      end
      salb_pkg::OpInitWr: begin
        rk_we  = 1'b1;
        rk_wa  = i_q[AW-1:0];
        rk_wd  = AW'(txt_rd);
        tmp_we = 1'b1;
        tmp_wa = i_q[AW-1:0];
        tmp_wd = i_q[AW-1:0];
        i_d    = sts_o.last ? '0 : i_q + LW'(1);
      end
      salb_pkg::OpClr: begin
        bkt_we = 1'b1;
        bkt_wa = i_q[AW-1:0];
        sum_d  = '0;
        i_d    = sts_o.last ? '0 : i_q + LW'(1);
      end
      salb_pkg::OpCnt1, salb_pkg::OpPlc1: begin
        tmp_ra = i_q[AW-1:0];
      end
      salb_pkg::OpCnt2, salb_pkg::OpPlc2: begin
        p_d   = tmp_rd;
        rk_ra = tmp_rd;
      end
      salb_pkg::OpCnt3, salb_pkg::OpPlc3: begin
        v_d    = rk_rd;
        bkt_ra = rk_rd;
      end
      salb_pkg::OpCnt4: begin
        bkt_we = 1'b1;
        bkt_wa = v_q;
        bkt_wd = bkt_rd + LW'(1);
        i_d    = sts_o.last ? '0 : i_q + LW'(1);
      end
      salb_pkg::OpPre1: begin
        bkt_ra = i_q[AW-1:0];
      end
      salb_pkg::OpPre2: begin
        bkt_we = 1'b1;
        bkt_wa = i_q[AW-1:0];
        bkt_wd = sum_q;
        sum_d  = sum_q + bkt_rd;
        i_d    = sts_o.last ? '0 : i_q + LW'(1);
      end
      salb_pkg::OpPlc4: begin
        sa_we  = 1'b1;
        sa_wa  = bkt_rd[AW-1:0];
        sa_wd  = p_q;
        bkt_we = 1'b1;
        bkt_wa = v_q;
        bkt_wd = bkt_rd + LW'(1);
        i_d    = sts_o.last ? '0 : i_q + LW'(1);
      end
      salb_pkg::OpSkInit: begin
        // Suffixes whose second half runs past the end sort first.
        i_d = (len_q > k_q) ? len_q - k_q : '0;
        w_d = '0;
      end
      salb_pkg::OpSkA: begin
        tmp_we = 1'b1;
        tmp_wa = w_q[AW-1:0];
        tmp_wd = i_q[AW-1:0];
        w_d    = w_q + LW'(1);
        i_d    = sts_o.last ? '0 : i_q + LW'(1);
      end
      salb_pkg::OpSkB1: begin
        sa_ra = i_q[AW-1:0];
      end
      salb_pkg::OpSkB2: begin
        if (LW'(sa_rd) >= k_q) begin
          tmp_we = 1'b1;
          tmp_wa = w_q[AW-1:0];
          tmp_wd = sa_rd - k_q[AW-1:0];
          w_d    = w_q + LW'(1);
        end
        i_d = sts_o.last ? '0 : i_q + LW'(1);
      end
      salb_pkg::OpCls1: begin
        sa_ra = i_q[AW-1:0];
      end
      salb_pkg::OpCls2: begin
        b_d   = sa_rd;
        rk_ra = sa_rd;
      end
      salb_pkg::OpCls3: begin
        k1_d  = rk_rd;
        inr_d = bk_sum < (LW+1)'(len_q);
        rk_ra = bk_sum[AW-1:0];
      end
      salb_pkg::OpCls4: begin
        cls_d  = (i_q == '0) ? '0 : cls_q + AW'(differ);
        rkn_we = 1'b1;
        rkn_wa = b_q;
        rkn_wd = cls_d;
        pk1_d  = k1_q;
        pinr_d = inr_q;
        pk2_d  = rk_rd;
        i_d    = sts_o.last ? '0 : i_q + LW'(1);
      end
      salb_pkg::OpCp1: begin
        rkn_ra = i_q[AW-1:0];
      end
      salb_pkg::OpCp2: begin
        rk_we = 1'b1;
        rk_wa = i_q[AW-1:0];
        rk_wd = rkn_rd;
        i_d   = sts_o.last ? '0 : i_q + LW'(1);
      end
      salb_pkg::OpRound: begin
        k_d = k_q << 1;
      end
      salb_pkg::OpIsa1: begin
        sa_ra = i_q[AW-1:0];
      end
      salb_pkg::OpIsa2: begin
        isa_we = 1'b1;
        isa_wa = sa_rd;
        isa_wd = i_q[AW-1:0];
        i_d    = sts_o.last ? '0 : i_q + LW'(1);
      end
      salb_pkg::OpLcp1: begin
        isa_ra = i_q[AW-1:0];
      end
      salb_pkg::OpLcp2: begin
        r_d = isa_rd;
        if (sts_o.zero) begin
          lcp_we = 1'b1;
          lcp_wa = '0;
          h_d    = '0;
          i_d    = sts_o.last ? '0 : i_q + LW'(1);
        end else begin
          sa_ra = isa_rd - AW'(1);
        end
      end
      salb_pkg::OpLcp3: begin
        j_d = sa_rd;
      end
      salb_pkg::OpLcp4: begin
        txt_ra = ih_sum[AW-1:0];
      end
      salb_pkg::OpLcp5: begin
        c_d    = txt_rd;
        txt_ra = jh_sum[AW-1:0];
      end
      salb_pkg::OpLcp6: begin
        if (sts_o.eq) begin
          h_d = h_q + LW'(1);
        end
      end
      salb_pkg::OpLcpEnd: begin
        lcp_we = 1'b1;
        lcp_wa = r_q;
        lcp_wd = h_q[AW-1:0];
        h_d    = (h_q != '0) ? h_q - LW'(1) : '0;
        i_d    = sts_o.last ? '0 : i_q + LW'(1);
      end
      salb_pkg::OpDone: begin
        built_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ovf_q   <= 1'b0;
      built_q <= 1'b0;
      qv_q    <= 1'b0;
      qbad_q  <= 1'b0;
      i_q     <= '0;
      w_q     <= '0;
      k_q     <= '0;
      h_q     <= '0;
      sum_q   <= '0;
      cls_q   <= '0;
    end else begin
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      built_q <= built_d;
      qv_q    <= qv_d;
      qbad_q  <= qbad_d;
      i_q     <= i_d;
      w_q     <= w_d;
      k_q     <= k_d;
      h_q     <= h_d;
      sum_q   <= sum_d;
      cls_q   <= cls_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    v_q    <= v_d;
    b_q    <= b_d;
    k1_q   <= k1_d;
    pk1_q  <= pk1_d;
    pk2_q  <= pk2_d;
    r_q    <= r_d;
    j_q    <= j_d;
    inr_q  <= inr_d;
    pinr_q <= pinr_d;
    c_q    <= c_d;
  end

  salb_ram #(.Width(SW), .Depth(salb_pkg::MaxLen)) u_txt (
    .clk_i, .we_i(txt_we), .waddr_i(txt_wa), .wdata_i(txt_wd), .raddr_i(txt_ra),
    .rdata_o(txt_rd)
  );
  salb_ram #(.Width(AW), .Depth(salb_pkg::MaxLen)) u_sa (
    .clk_i, .we_i(sa_we), .waddr_i(sa_wa), .wdata_i(sa_wd), .raddr_i(sa_ra),
    .rdata_o(sa_rd)
  );
  salb_ram #(.Width(AW), .Depth(salb_pkg::MaxLen)) u_tmp (
    .clk_i, .we_i(tmp_we), .waddr_i(tmp_wa), .wdata_i(tmp_wd), .raddr_i(tmp_ra),
    .rdata_o(tmp_rd)
  );
  salb_ram #(.Width(AW), .Depth(salb_pkg::MaxLen)) u_rk (
    .clk_i, .we_i(rk_we), .waddr_i(rk_wa), .wdata_i(rk_wd), .raddr_i(rk_ra),
    .rdata_o(rk_rd)
  );
  salb_ram #(.Width(AW), .Depth(salb_pkg::MaxLen)) u_rkn (
    .clk_i, .we_i(rkn_we), .waddr_i(rkn_wa), .wdata_i(rkn_wd), .raddr_i(rkn_ra),
    .rdata_o(rkn_rd)
  );
  salb_ram #(.Width(LW), .Depth(salb_pkg::MaxLen)) u_bkt (
    .clk_i, .we_i(bkt_we), .waddr_i(bkt_wa), .wdata_i(bkt_wd), .raddr_i(bkt_ra),
    .rdata_o(bkt_rd)
  );
  salb_ram #(.Width(AW), .Depth(salb_pkg::MaxLen)) u_isa (
    .clk_i, .we_i(isa_we), .waddr_i(isa_wa), .wdata_i(isa_wd), .raddr_i(isa_ra),
    .rdata_o(isa_rd)
  );
  salb_ram #(.Width(AW), .Depth(salb_pkg::MaxLen)) u_lcp (
    .clk_i, .we_i(lcp_we), .waddr_i(lcp_wa), .wdata_i(lcp_wd), .raddr_i(lcp_ra),
    .rdata_o(lcp_rd)
  );

  assign result_valid_o = qv_q || (ctl_i.op == salb_pkg::OpDone);
  assign position_o     = (qv_q && !qbad_q) ? sa_rd : '0;
  assign lcp_o          = (qv_q && !qbad_q) ? lcp_rd : '0;
  assign text_len_o     = len_q;
  assign status_o       = (ctl_i.op == salb_pkg::OpDone) ?
                          (ovf_q ? salb_pkg::StTrunc : salb_pkg::StOk) :
                          (qbad_q ? salb_pkg::StBad : salb_pkg::StOk);

endmodule

`default_nettype wire

// File: rtl/core/salb_ctrl.sv
// Build sequencer of the suffix array core: walks the sort, doubling and LCP passes.
// Depends on salb_pkg; its commands drive salb_datapath.
`default_nettype none

module salb_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [salb_pkg::CmdW-1:0] cmd_i,
  input  salb_pkg::sts_t            sts_i,
  output salb_pkg::ctl_t            ctl_o
);

  typedef enum logic [5:0] {
    StIdle, StInitRd, StInitWr, StClr,
    StCnt1, StCnt2, StCnt3, StCnt4,
    StPre1, StPre2,
    StPlc1, StPlc2, StPlc3, StPlc4,
    StSkInit, StSkA, StSkB1, StSkB2,
    StCls1, StCls2, StCls3, StCls4,
    StCp1, StCp2, StRound,
    StIsa1, StIsa2,
    StLcp1, StLcp2, StLcp3, StLcp4, StLcp5, StLcp6, StLcpEnd,
    StDone
  } state_e;

  state_e         state_q, state_d;
  logic           first_q, first_d;
  salb_pkg::ctl_t ctl_q, ctl_d;

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    unique case (state_q)
      StIdle: begin
        if (start_i && !ctl_q.busy && cmd_i == salb_pkg::CmdBuild) begin
          state_d = sts_i.empty ? StDone : StInitRd;
          first_d = 1'b1;
        end
      end
      StInitRd: state_d = StInitWr;
      StInitWr: state_d = sts_i.last ? StClr : StInitRd;
      StClr:    state_d = sts_i.last ? StCnt1 : StClr;
      StCnt1:   state_d = StCnt2;
      StCnt2:   state_d = StCnt3;
      StCnt3:   state_d = StCnt4;
      StCnt4:   state_d = sts_i.last ? StPre1 : StCnt1;
      StPre1:   state_d = StPre2;
      StPre2:   state_d = sts_i.last ? StPlc1 : StPre1;
      StPlc1:   state_d = StPlc2;
      StPlc2:   state_d = StPlc3;
      StPlc3:   state_d = StPlc4;
      StPlc4: begin
        if (sts_i.last) begin
          // The first sort orders by symbol alone; later sorts feed the class pass.
          state_d = first_q ? StSkInit : StCls1;
          first_d = 1'b0;
        end else begin
          state_d = StPlc1;
        end
      end
      StSkInit: state_d = StSkA;
      StSkA:    state_d = sts_i.last ? StSkB1 : StSkA;
      StSkB1:   state_d = StSkB2;
      StSkB2:   state_d = sts_i.last ? StClr : StSkB1;
      StCls1:   state_d = StCls2;
      StCls2:   state_d = StCls3;
      StCls3:   state_d = StCls4;
      StCls4:   state_d = sts_i.last ? StCp1 : StCls1;
      StCp1:    state_d = StCp2;
      StCp2:    state_d = sts_i.last ? StRound : StCp1;
      StRound:  state_d = sts_i.sorted ? StIsa1 : StSkInit;
      StIsa1:   state_d = StIsa2;
      StIsa2:   state_d = sts_i.last ? StLcp1 : StIsa1;
      StLcp1:   state_d = StLcp2;
      StLcp2: begin
        if (sts_i.zero) begin
          state_d = sts_i.last ? StDone : StLcp1;
        end else begin
          state_d = StLcp3;
        end
      end
      StLcp3:   state_d = StLcp4;
      StLcp4:   state_d = sts_i.more ? StLcp5 : StLcpEnd;
      StLcp5:   state_d = StLcp6;
      StLcp6:   state_d = sts_i.eq ? StLcp4 : StLcpEnd;
      StLcpEnd: state_d = sts_i.last ? StDone : StLcp1;
      StDone:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    ctl_d.busy = (state_d != StIdle);
    unique case (state_d)
      StIdle:   ctl_d.op = salb_pkg::OpIdle;
      StInitRd: ctl_d.op = salb_pkg::OpInitRd;
      StInitWr: ctl_d.op = salb_pkg::OpInitWr;
      StClr:    ctl_d.op = salb_pkg::OpClr;
      StCnt1:   ctl_d.op = salb_pkg::OpCnt1;
      StCnt2:   ctl_d.op = salb_pkg::OpCnt2;
      StCnt3:   ctl_d.op = salb_pkg::OpCnt3;
      StCnt4:   ctl_d.op = salb_pkg::OpCnt4;
      StPre1:   ctl_d.op = salb_pkg::OpPre1;
      StPre2:   ctl_d.op = salb_pkg::OpPre2;
      StPlc1:   ctl_d.op = salb_pkg::OpPlc1;
      StPlc2:   ctl_d.op = salb_pkg::OpPlc2;
      StPlc3:   ctl_d.op = salb_pkg::OpPlc3;
      StPlc4:   ctl_d.op = salb_pkg::OpPlc4;
      StSkInit: ctl_d.op = salb_pkg::OpSkInit;
      StSkA:    ctl_d.op = salb_pkg::OpSkA;
      StSkB1:   ctl_d.op = salb_pkg::OpSkB1;
      StSkB2:   ctl_d.op = salb_pkg::OpSkB2;
      StCls1:   ctl_d.op = salb_pkg::OpCls1;
      StCls2:   ctl_d.op = salb_pkg::OpCls2;
      StCls3:   ctl_d.op = salb_pkg::OpCls3;
      StCls4:   ctl_d.op = salb_pkg::OpCls4;
      StCp1:    ctl_d.op = salb_pkg::OpCp1;
      StCp2:    ctl_d.op = salb_pkg::OpCp2;
      StRound:  ctl_d.op = salb_pkg::OpRound;
      StIsa1:   ctl_d.op = salb_pkg::OpIsa1;
      StIsa2:   ctl_d.op = salb_pkg::OpIsa2;
      StLcp1:   ctl_d.op = salb_pkg::OpLcp1;
      StLcp2:   ctl_d.op = salb_pkg::OpLcp2;
      StLcp3:   ctl_d.op = salb_pkg::OpLcp3;
      StLcp4:   ctl_d.op = salb_pkg::OpLcp4;
      StLcp5:   ctl_d.op = salb_pkg::OpLcp5;
      StLcp6:   ctl_d.op = salb_pkg::OpLcp6;
      StLcpEnd: ctl_d.op = salb_pkg::OpLcpEnd;
      StDone:   ctl_d.op = salb_pkg::OpDone;
      default:  ctl_d.op = salb_pkg::OpIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      first_q    <= 1'b0;
      ctl_q.op   <= salb_pkg::OpIdle;
      ctl_q.busy <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      ctl_q   <= ctl_d;
    end
  end

  assign ctl_o = ctl_q;

endmodule

`default_nettype wire

// File: rtl/core/suffix_array_lcp_builder_core.sv
// Top level of the suffix array and LCP builder core.
// Depends on salb_pkg, salb_ctrl, salb_datapath and the assertion macro header.
//
// Append and read commands are taken one per clock while busy is low. A read
// answers with a one-cycle result_valid_o strobe in the cycle after it is
// accepted; an append gives no result. A build command raises busy and walks
// the single-write, single-read RAMs through the initial symbol sort, then
// through prefix-doubling rounds (one round per doubling of the longest
// repeated prefix, at most log2(n) + 1, where n is the string length), then
// through the LCP pass. The build result strobes in the last busy cycle. The
// receiver cannot stall: every strobe is a finished transaction.
`default_nettype none
`include "suffix_array_lcp_builder_core_assert.svh"

module suffix_array_lcp_builder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [salb_pkg::CmdW-1:0]   cmd_i,
  input  logic [salb_pkg::SymW-1:0]   symbol_i,
  input  logic [salb_pkg::LenW-1:0]   rank_i,
  output logic                        result_valid_o,
  output logic [salb_pkg::AddrW-1:0]  position_o,
  output logic [salb_pkg::AddrW-1:0]  lcp_o,
  output logic [salb_pkg::LenW-1:0]   text_len_o,
  output logic [salb_pkg::StatW-1:0]  status_o
);

  salb_pkg::ctl_t ctl;
  salb_pkg::sts_t sts;

  salb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i (start),
    .cmd_i,
    .sts_i   (sts),
    .ctl_o   (ctl)
  );

  salb_datapath u_datapath (
    .clk_i,
    .rst_ni,
    .ctl_i          (ctl),
    .sts_o          (sts),
    .start_i        (start),
    .cmd_i,
    .symbol_i,
    .rank_i,
    .result_valid_o,
    .position_o,
    .lcp_o,
    .text_len_o,
    .status_o
  );

  assign busy = ctl.busy;

  `SALB_ASSERT_NEXT(a_read_answers, clk_i, rst_ni, start && !busy && cmd_i == salb_pkg::CmdRead, result_valid_o)
  `SALB_ASSERT_NEXT(a_append_silent, clk_i, rst_ni, start && !busy && cmd_i == salb_pkg::CmdAppend, !result_valid_o)
  `SALB_ASSERT_NEXT(a_build_busy, clk_i, rst_ni, start && !busy && cmd_i == salb_pkg::CmdBuild, busy)

endmodule

`default_nettype wire
